// ===== hw/rtl/bsc_pkg.sv =====
// Shared types and constants for the barometric sensor compensation block.
// Depends on nothing; used by baro_sensor_compensation.
`default_nettype none

package bsc_pkg;

	localparam int unsigned NUM_STG   = 9;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned RAW_W     = 24;
	localparam int unsigned TEMP_W    = 20;
	localparam int unsigned PRESS_W   = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_SENS   = 3'd0,
		REG_PRESS_OFFS   = 3'd1,
		REG_SENS_TCOEF   = 3'd2,
		REG_OFFS_TCOEF   = 3'd3,
		REG_REF_TEMP     = 3'd4,
		REG_TEMP_SLOPE   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0]  temperature_centi;
		logic signed [PRESS_W-1:0] pressure_centi;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/baro_sensor_compensation.sv =====
// Barometric sensor compensation: first- and second-order datasheet correction.
// Depends on bsc_pkg (item types, register index codes, widths).
//
// Nine-stage pipeline: one item enters per cycle while the input is not stalled, and
// its result leaves from the last stage. Stage depth is set by the multipliers: the 25x25 square of the
// temperature difference, and the 24x40 pressure product, split into two
// 24x20 partial products summed in the following stage. Stalls back up stage
// by stage and empty stages fill, so nothing is lost or repeated.
// Calibration registers are read live by the stages; write them only when idle.
`default_nettype none

module baro_sensor_compensation (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      sample_valid,
	output logic                           sample_stall,
	input  wire bsc_pkg::sample_t          sample,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output bsc_pkg::result_t               result,
	input  wire logic                      cfg_wr_en,
	input  wire logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [bsc_pkg::CFG_W-1:0] cfg_data
);

	// calibration words
	logic [15:0] c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q <= '0;
			c2_q <= '0;
			c3_q <= '0;
			c4_q <= '0;
			c5_q <= '0;
			c6_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				bsc_pkg::REG_PRESS_SENS: c1_q <= cfg_data;
				bsc_pkg::REG_PRESS_OFFS: c2_q <= cfg_data;
				bsc_pkg::REG_SENS_TCOEF: c3_q <= cfg_data;
				bsc_pkg::REG_OFFS_TCOEF: c4_q <= cfg_data;
				bsc_pkg::REG_REF_TEMP:   c5_q <= cfg_data;
				bsc_pkg::REG_TEMP_SLOPE: c6_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake: valid per stage, advance ripples back from the output
	logic [bsc_pkg::NUM_STG-1:0] vld_q;
	logic [bsc_pkg::NUM_STG-1:0] adv;

	always_comb begin
		adv[bsc_pkg::NUM_STG-1] = !vld_q[bsc_pkg::NUM_STG-1] || !result_stall;
		for (int k = bsc_pkg::NUM_STG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= sample_valid;
			end
			for (int k = 1; k < bsc_pkg::NUM_STG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign sample_stall = !adv[0];
	assign result_valid = vld_q[bsc_pkg::NUM_STG-1];

	// payload registers
	logic        [23:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic signed [24:0] dt_s1;
	logic signed [41:0] mt_s2, mo_s2, ms_s2;
	logic        [47:0] mdd_s2;
	logic signed [19:0] t_s3;
	logic signed [39:0] offs_s3, sns_s3, offs_s4, sns_s4;
	logic        [16:0] t2_s3;
	logic        [35:0] lo2_s4, vlo2_s4;
	logic               low_s4, vlow_s4;
	logic signed [19:0] tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9;
	logic signed [39:0] offc_s5, snsc_s5, offc_s6, offc_s7;
	logic        [43:0] pl_s6;
	logic signed [43:0] ph_s6;
	logic signed [63:0] prod_s7;
	logic signed [43:0] d_s8;
	logic signed [31:0] pr_s9;

	// stage combinational terms
	logic signed [24:0] dt_c;
	logic signed [41:0] mt_c, mo_c, ms_c;
	logic signed [49:0] mdd_c;
	logic signed [41:0] t_adj, t_div, t_sum;
	logic signed [41:0] o_adj, o_div, o_sum;
	logic signed [41:0] s_adj, s_div, s_sum;
	logic signed [19:0] lo_c, vlo_c, tf_c;
	logic signed [39:0] lo2_c, vlo2_c;
	logic        [39:0] l5_c, v7_c, v11_c, off2_c, sn2_c;
	logic        [43:0] pl_c;
	logic signed [44:0] ph_c;
	logic signed [63:0] q_adj, q_div, d_c;
	logic signed [43:0] p_adj, p_div;
	logic signed [31:0] pr_c;

	always_comb begin
		// s1: temperature difference
		dt_c = $signed({1'b0, sample.raw_temperature}) - $signed({1'b0, c5_q, 8'd0});

		// s2: products on dT
		mt_c  = dt_s1 * $signed({1'b0, c6_q});
		mo_c  = dt_s1 * $signed({1'b0, c4_q});
		ms_c  = dt_s1 * $signed({1'b0, c3_q});
		mdd_c = dt_s1 * dt_s1;

		// s3: truncating shifts, first-order terms
		t_adj = mt_s2 + (mt_s2[41] ? 42'sd8388607 : 42'sd0);
		t_div = t_adj >>> 23;
		t_sum = t_div + 42'sd2000;
		o_adj = mo_s2 + (mo_s2[41] ? 42'sd127 : 42'sd0);
		o_div = o_adj >>> 7;
		o_sum = o_div + $signed({10'd0, c2_q, 16'd0});
		s_adj = ms_s2 + (ms_s2[41] ? 42'sd255 : 42'sd0);
		s_div = s_adj >>> 8;
		s_sum = s_div + $signed({11'd0, c1_q, 15'd0});

		// s4: squares for the second-order terms
		lo_c   = t_s3 - 20'sd2000;
		vlo_c  = t_s3 + 20'sd1500;
		lo2_c  = lo_c * lo_c;
		vlo2_c = vlo_c * vlo_c;
		tf_c   = (t_s3 < 20'sd2000) ? (t_s3 - $signed({3'd0, t2_s3})) : t_s3;

		// s5: offset and sensitivity corrections
		l5_c   = {4'd0, lo2_s4} + {2'd0, lo2_s4, 2'd0};
		v7_c   = {1'b0, vlo2_s4, 3'd0} - {4'd0, vlo2_s4};
		v11_c  = {1'b0, vlo2_s4, 3'd0} + {3'd0, vlo2_s4, 1'b0} + {4'd0, vlo2_s4};
		off2_c = (l5_c >> 1) + (vlow_s4 ? v7_c : 40'd0);
		sn2_c  = (l5_c >> 2) + (vlow_s4 ? (v11_c >> 1) : 40'd0);

		// s6: pressure product, split in two halves of sensitivity
		pl_c = {20'd0, rp_s5} * {24'd0, snsc_s5[19:0]};
		ph_c = $signed({1'b0, rp_s5}) * $signed(snsc_s5[39:20]);

		// s8: divide by 2^21 toward zero, subtract offset
		q_adj = prod_s7 + (prod_s7[63] ? 64'sd2097151 : 64'sd0);
		q_div = q_adj >>> 21;
		d_c   = q_div - {{24{offc_s7[39]}}, offc_s7};

		// s9: divide by 2^15 toward zero, saturate
		p_adj = d_s8 + (d_s8[43] ? 44'sd32767 : 44'sd0);
		p_div = p_adj >>> 15;
		if (p_div > 44'sd2147483647) begin
			pr_c = 32'sh7fffffff;
		end else if (p_div < -44'sd2147483648) begin
			pr_c = 32'sh80000000;
		end else begin
			pr_c = p_div[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rp_s1 <= sample.raw_pressure;
			dt_s1 <= dt_c;
		end
		if (adv[1]) begin
			rp_s2  <= rp_s1;
			mt_s2  <= mt_c;
			mo_s2  <= mo_c;
			ms_s2  <= ms_c;
			mdd_s2 <= mdd_c[47:0];
		end
		if (adv[2]) begin
			rp_s3   <= rp_s2;
			t_s3    <= t_sum[19:0];
			offs_s3 <= o_sum[39:0];
			sns_s3  <= s_sum[39:0];
			t2_s3   <= mdd_s2[47:31];
		end
		if (adv[3]) begin
			rp_s4   <= rp_s3;
			offs_s4 <= offs_s3;
			sns_s4  <= sns_s3;
			lo2_s4  <= lo2_c[35:0];
			vlo2_s4 <= vlo2_c[35:0];
			low_s4  <= t_s3 < 20'sd2000;
			vlow_s4 <= t_s3 < -20'sd1500;
			tf_s4   <= tf_c;
		end
		if (adv[4]) begin
			rp_s5   <= rp_s4;
			tf_s5   <= tf_s4;
			offc_s5 <= low_s4 ? (offs_s4 - $signed(off2_c)) : offs_s4;
			snsc_s5 <= low_s4 ? (sns_s4 - $signed(sn2_c)) : sns_s4;
		end
		if (adv[5]) begin
			tf_s6   <= tf_s5;
			offc_s6 <= offc_s5;
			pl_s6   <= pl_c;
			ph_s6   <= ph_c[43:0];
		end
		if (adv[6]) begin
			tf_s7   <= tf_s6;
			offc_s7 <= offc_s6;
			prod_s7 <= $signed({ph_s6, 20'd0}) + $signed({20'd0, pl_s6});
		end
		if (adv[7]) begin
			tf_s8 <= tf_s7;
			d_s8  <= d_c[43:0];
		end
		if (adv[8]) begin
			tf_s9 <= tf_s8;
			pr_s9 <= pr_c;
		end
	end

	assign result.temperature_centi = tf_s9;
	assign result.pressure_centi    = pr_s9;

	// full pipe held at the output must push back on the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&vld_q && result_stall) |-> sample_stall)
		else $error("full pipe accepted an item");

	// an item held in the fifth stage stays there
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[4] && !adv[4]) |=> vld_q[4])
		else $error("held item dropped");

	// every accepted item lands in the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> vld_q[0])
		else $error("accepted item lost");

	// compensated temperature stays within its physical span
	a_temp_span: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.temperature_centi >= -20'sd300000 &&
			result.temperature_centi <= 20'sd300000))
		else $error("temperature out of span");

endmodule

`default_nettype wire
